// ----- hw/rtl/aarm_pkg.sv -----
`timescale 1ns / 1ps
package aarm_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int QUOT_W       = 34;
  localparam int DIV_LANES    = 9;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0]        angle;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_axis;
  } out_word_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [4:0]         idx;
    logic [1:0]         quad;
  } cc_word_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_word_t;

  typedef struct packed {
    logic [31:0]       rem;
    logic [QUOT_W-1:0] lq;
    logic [31:0]       den;
    logic              neg;
  } dv_word_t;

  function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sh20000000;
      5'd1:  v = 34'sh12E4051E;
      5'd2:  v = 34'sh09FB385B;
      5'd3:  v = 34'sh051111D4;
      5'd4:  v = 34'sh028B0D43;
      5'd5:  v = 34'sh0145D7E1;
      5'd6:  v = 34'sh00A2F61E;
      5'd7:  v = 34'sh00517C55;
      5'd8:  v = 34'sh0028BE53;
      5'd9:  v = 34'sh00145F2F;
      5'd10: v = 34'sh000A2F98;
      5'd11: v = 34'sh000517CC;
      5'd12: v = 34'sh00028BE6;
      5'd13: v = 34'sh000145F3;
      5'd14: v = 34'sh0000A2FA;
      5'd15: v = 34'sh0000517D;
      5'd16: v = 34'sh000028BE;
      5'd17: v = 34'sh0000145F;
      5'd18: v = 34'sh00000A30;
      5'd19: v = 34'sh00000518;
      5'd20: v = 34'sh0000028C;
      5'd21: v = 34'sh00000146;
      5'd22: v = 34'sh000000A3;
      5'd23: v = 34'sh00000051;
      5'd24: v = 34'sh00000029;
      5'd25: v = 34'sh00000014;
      5'd26: v = 34'sh0000000A;
      5'd27: v = 34'sh00000005;
      5'd28: v = 34'sh00000003;
      5'd29: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/aarm_cordic_cell.sv -----
`timescale 1ns / 1ps
module aarm_cordic_cell (
  input  logic               clk,
  input  aarm_pkg::cc_word_t cin,
  output aarm_pkg::cc_word_t cout
);
  import aarm_pkg::*;

  cc_word_t           cell_r;
  cc_word_t           cell_nxt;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;

  always_comb begin
    dx = cin.y >>> cin.idx;
    dy = cin.x >>> cin.idx;
    at = atan_lut(cin.idx);
    cell_nxt = cin;
    if (!cin.z[33]) begin
      cell_nxt.x = cin.x - dx;
      cell_nxt.y = cin.y + dy;
      cell_nxt.z = cin.z - at;
    end else begin
      cell_nxt.x = cin.x + dx;
      cell_nxt.y = cin.y - dy;
      cell_nxt.z = cin.z + at;
    end
    cell_nxt.idx = cin.idx + 5'd1;
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cout = cell_r;

endmodule

// ----- hw/rtl/aarm_sqrt_cell.sv -----
`timescale 1ns / 1ps
module aarm_sqrt_cell (
  input  logic               clk,
  input  aarm_pkg::sq_word_t cin,
  output aarm_pkg::sq_word_t cout
);
  import aarm_pkg::*;

  sq_word_t    cell_r;
  sq_word_t    cell_nxt;
  logic [35:0] r;
  logic [35:0] trial;

  always_comb begin
    r     = {cin.rem, cin.rad[63:62]};
    trial = {2'b00, cin.root, 2'b01};
    cell_nxt.rad = {cin.rad[61:0], 2'b00};
    if (r >= trial) begin
      cell_nxt.rem  = 34'(r - trial);
      cell_nxt.root = {cin.root[30:0], 1'b1};
    end else begin
      cell_nxt.rem  = r[33:0];
      cell_nxt.root = {cin.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cout = cell_r;

endmodule

// ----- hw/rtl/aarm_div_cell.sv -----
`timescale 1ns / 1ps
module aarm_div_cell (
  input  logic               clk,
  input  aarm_pkg::dv_word_t cin,
  output aarm_pkg::dv_word_t cout
);
  import aarm_pkg::*;

  dv_word_t    cell_r;
  dv_word_t    cell_nxt;
  logic [32:0] r2;
  logic        ge;

  always_comb begin
    r2 = {cin.rem, cin.lq[QUOT_W-1]};
    ge = r2 >= {1'b0, cin.den};
    cell_nxt = cin;
    cell_nxt.rem = ge ? 32'(r2 - {1'b0, cin.den}) : r2[31:0];
    cell_nxt.lq  = {cin.lq[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cout = cell_r;

endmodule

// ----- hw/rtl/axis_angle_rotation_matrix_unit.sv -----
`timescale 1ns / 1ps
// a word accepted at a clock edge comes out with out_strobe after passing the cordic, square-root
// and divider cells; throughput: one word per cycle, busy is always low;
// the pipeline of cordic, square-root and divider cells never stalls, and the receiver
// cannot hold results off
// reset: synchronous active-low rst_n clears only the valid pipeline; words in flight are dropped
module axis_angle_rotation_matrix_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  aarm_pkg::in_word_t  in_data,
  output logic                out_strobe,
  output aarm_pkg::out_word_t out_data
);
  import aarm_pkg::*;

  localparam int LAST = 68;

  function automatic logic signed [15:0] to_q14(input logic signed [36:0] v);
    logic signed [36:0] t;
    logic signed [36:0] r;
    logic signed [15:0] o;
    t = v + 37'sd32768;
    r = t >>> 16;
    if (r > 37'sd16384) o = 16'sd16384;
    else if (r < -37'sd16384) o = -16'sd16384;
    else o = r[15:0];
    return o;
  endfunction

  logic [LAST:0]      v_r;
  logic               acc;
  logic [15:0]        ang_off;
  logic [1:0]         quad0;
  logic [15:0]        res16;
  cc_word_t           cc0_r;
  cc_word_t           cc [0:CORDIC_STEPS];
  sq_word_t           sq [0:SQRT_STEPS];
  dv_word_t           dv [0:DIV_LANES-1][0:QUOT_W];
  logic signed [15:0] ax_d [0:31];
  logic signed [15:0] ay_d [0:31];
  logic signed [15:0] az_d [0:31];
  logic [31:0]        pxx_r, pyy_r, pzz_r;
  logic [31:0]        n2_d [1:33];
  logic               zr_d [0:67];
  logic signed [33:0] c_d [31:67];
  logic signed [33:0] c_nxt, s_nxt;
  logic signed [33:0] s31_r, omc31_r;
  logic signed [31:0] pij31_r [0:5];
  logic signed [63:0] prod32_r [0:DIV_LANES-1];
  logic [62:0]        mag33_r [0:DIV_LANES-1];
  logic               neg33_r [0:DIV_LANES-1];
  logic signed [35:0] q [0:DIV_LANES-1];
  logic signed [36:0] cc67;
  out_word_t          out_r;
  out_word_t          out_nxt;

  assign busy    = 1'b0;
  assign acc     = start && !busy;
  assign ang_off = in_data.angle + 16'h2000;
  assign quad0   = ang_off[15:14];
  assign res16   = in_data.angle - {quad0, 14'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAST-1:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    cc0_r.x    <= CORDIC_GAIN;
    cc0_r.y    <= '0;
    cc0_r.z    <= {{2{res16[15]}}, res16, 16'b0};
    cc0_r.idx  <= '0;
    cc0_r.quad <= quad0;
    ax_d[0]    <= in_data.axis_x;
    ay_d[0]    <= in_data.axis_y;
    az_d[0]    <= in_data.axis_z;
    pxx_r      <= 32'(in_data.axis_x * in_data.axis_x);
    pyy_r      <= 32'(in_data.axis_y * in_data.axis_y);
    pzz_r      <= 32'(in_data.axis_z * in_data.axis_z);
    zr_d[0]    <= (in_data.axis_x == 16'sd0) && (in_data.axis_y == 16'sd0) &&
                  (in_data.axis_z == 16'sd0);
    for (int k = 1; k <= 31; k++) begin
      ax_d[k] <= ax_d[k-1];
      ay_d[k] <= ay_d[k-1];
      az_d[k] <= az_d[k-1];
    end
    for (int k = 1; k <= 67; k++) begin
      zr_d[k] <= zr_d[k-1];
    end
    n2_d[1] <= pxx_r + pyy_r + pzz_r;
    for (int k = 2; k <= 33; k++) begin
      n2_d[k] <= n2_d[k-1];
    end
  end

  assign cc[0] = cc0_r;

  genvar g, l;
  generate
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      aarm_cordic_cell u_cell (.clk(clk), .cin(cc[g]), .cout(cc[g+1]));
    end
  endgenerate

  assign sq[0] = '{rem: '0, root: '0, rad: {n2_d[1], 32'b0}};

  generate
    for (g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      aarm_sqrt_cell u_cell (.clk(clk), .cin(sq[g]), .cout(sq[g+1]));
    end
  endgenerate

  // quadrant fold of the cordic result
  always_comb begin
    case (cc[CORDIC_STEPS].quad)
      2'd0: begin
        c_nxt = cc[CORDIC_STEPS].x;
        s_nxt = cc[CORDIC_STEPS].y;
      end
      2'd1: begin
        c_nxt = -cc[CORDIC_STEPS].y;
        s_nxt = cc[CORDIC_STEPS].x;
      end
      2'd2: begin
        c_nxt = -cc[CORDIC_STEPS].x;
        s_nxt = -cc[CORDIC_STEPS].y;
      end
      default: begin
        c_nxt = cc[CORDIC_STEPS].y;
        s_nxt = -cc[CORDIC_STEPS].x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    c_d[31]    <= c_nxt;
    s31_r      <= s_nxt;
    omc31_r    <= ONE_Q30 - c_nxt;
    pij31_r[0] <= 32'(ax_d[30] * ax_d[30]);
    pij31_r[1] <= 32'(ay_d[30] * ay_d[30]);
    pij31_r[2] <= 32'(az_d[30] * az_d[30]);
    pij31_r[3] <= 32'(ax_d[30] * ay_d[30]);
    pij31_r[4] <= 32'(ay_d[30] * az_d[30]);
    pij31_r[5] <= 32'(az_d[30] * ax_d[30]);
    for (int k = 32; k <= 67; k++) begin
      c_d[k] <= c_d[k-1];
    end
    for (int k = 0; k < 6; k++) begin
      prod32_r[k] <= 64'(omc31_r * pij31_r[k]);
    end
    prod32_r[6] <= {48'(s31_r * ax_d[31]), 16'b0};
    prod32_r[7] <= {48'(s31_r * ay_d[31]), 16'b0};
    prod32_r[8] <= {48'(s31_r * az_d[31]), 16'b0};
    for (int k = 0; k < DIV_LANES; k++) begin
      neg33_r[k] <= prod32_r[k][63];
      mag33_r[k] <= prod32_r[k][63] ? 63'(-prod32_r[k]) : prod32_r[k][62:0];
    end
  end

  generate
    for (l = 0; l < DIV_LANES; l++) begin : g_lane
      logic [31:0] den;
      logic [63:0] num;
      if (l < 6) begin : g_den_a
        assign den = n2_d[33];
      end else begin : g_den_b
        assign den = sq[SQRT_STEPS].root;
      end
      assign num = {1'b0, mag33_r[l]} + {33'b0, den[31:1]};
      assign dv[l][0] = '{rem: {2'b00, num[63:QUOT_W]}, lq: num[QUOT_W-1:0],
                          den: den, neg: neg33_r[l]};
      for (g = 0; g < QUOT_W; g++) begin : g_div
        aarm_div_cell u_cell (.clk(clk), .cin(dv[l][g]), .cout(dv[l][g+1]));
      end
      assign q[l] = dv[l][QUOT_W].neg ? -$signed({2'b00, dv[l][QUOT_W].lq})
                                      : $signed({2'b00, dv[l][QUOT_W].lq});
    end
  endgenerate

  assign cc67 = 37'(c_d[67]);

  always_comb begin
    if (zr_d[67]) begin
      out_nxt           = '0;
      out_nxt.m00       = 16'sd16384;
      out_nxt.m11       = 16'sd16384;
      out_nxt.m22       = 16'sd16384;
      out_nxt.zero_axis = 1'b1;
    end else begin
      out_nxt.m00       = to_q14(cc67 + 37'(q[0]));
      out_nxt.m01       = to_q14(37'(q[3]) - 37'(q[8]));
      out_nxt.m02       = to_q14(37'(q[5]) + 37'(q[7]));
      out_nxt.m10       = to_q14(37'(q[3]) + 37'(q[8]));
      out_nxt.m11       = to_q14(cc67 + 37'(q[1]));
      out_nxt.m12       = to_q14(37'(q[4]) - 37'(q[6]));
      out_nxt.m20       = to_q14(37'(q[5]) - 37'(q[7]));
      out_nxt.m21       = to_q14(37'(q[4]) + 37'(q[6]));
      out_nxt.m22       = to_q14(cc67 + 37'(q[2]));
      out_nxt.zero_axis = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data   = out_r;
  assign out_strobe = v_r[LAST];

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import aarm_pkg::*;

  localparam int LATENCY = 69;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_strobe;
  in_word_t in_data = '0;
  out_word_t out_data;

  int mismatches = 0;
  longint cycles = 0;
  int words_sent = 0;
  int zero_axis_seen = 0;

  always #2 clk = ~clk;

  axis_angle_rotation_matrix_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data)
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  function automatic longint fshift(input longint v, input int n);
    return (v >= 0) ? (v >>> n) : ~((~v) >>> n);
  endfunction

  function automatic longint atan_step(input int i);
    case (i)
      0: return 64'h20000000;   1: return 64'h12E4051E;   2: return 64'h09FB385B;
      3: return 64'h051111D4;   4: return 64'h028B0D43;   5: return 64'h0145D7E1;
      6: return 64'h00A2F61E;   7: return 64'h00517C55;   8: return 64'h0028BE53;
      9: return 64'h00145F2F;  10: return 64'h000A2F98;  11: return 64'h000517CC;
      12: return 64'h00028BE6; 13: return 64'h000145F3;  14: return 64'h0000A2FA;
      15: return 64'h0000517D; 16: return 64'h000028BE;  17: return 64'h0000145F;
      18: return 64'h00000A30; 19: return 64'h00000518;  20: return 64'h0000028C;
      21: return 64'h00000146; 22: return 64'h000000A3;  23: return 64'h00000051;
      24: return 64'h00000029; 25: return 64'h00000014;  26: return 64'h0000000A;
      27: return 64'h00000005; 28: return 64'h00000003;  default: return 64'h1;
    endcase
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint rdiv(input longint num, input longint den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] to_q14(input longint v);
    longint r;
    r = fshift(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic out_word_t rotation_of(input in_word_t w);
    out_word_t o;
    longint ax, ay, az, n2, c, s, omc, len, x, y, z, dx, dy;
    longint axx, ayy, azz, axy, ayz, azx, bx, by, bz;
    logic [31:0] phase, res;
    logic [1:0] quad;
    ax = w.axis_x;
    ay = w.axis_y;
    az = w.axis_z;
    n2 = ax * ax + ay * ay + az * az;
    o = '0;
    if (n2 == 0) begin
      o.m00 = 16384; o.m11 = 16384; o.m22 = 16384; o.zero_axis = 1'b1;
      return o;
    end
    phase = {w.angle, 16'h0};
    quad = 2'((phase + 32'h20000000) >> 30);
    res = phase - {quad, 30'h0};
    z = longint'($signed(res));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    omc = 64'd1073741824 - c;
    len = int_sqrt(longint'(n2) << 32);
    axx = rdiv(omc * (ax * ax), n2);
    ayy = rdiv(omc * (ay * ay), n2);
    azz = rdiv(omc * (az * az), n2);
    axy = rdiv(omc * (ax * ay), n2);
    ayz = rdiv(omc * (ay * az), n2);
    azx = rdiv(omc * (az * ax), n2);
    bx = rdiv(s * ax * 65536, len);
    by = rdiv(s * ay * 65536, len);
    bz = rdiv(s * az * 65536, len);
    o.m00 = to_q14(c + axx);   o.m01 = to_q14(axy - bz); o.m02 = to_q14(azx + by);
    o.m10 = to_q14(axy + bz);  o.m11 = to_q14(c + ayy);  o.m12 = to_q14(ayz - bx);
    o.m20 = to_q14(azx - by);  o.m21 = to_q14(ayz + bx); o.m22 = to_q14(c + azz);
    return o;
  endfunction

  class matrix_scoreboard;
    out_word_t pending[$];

    function void note_word(in_word_t w);
      pending.push_back(rotation_of(w));
    endfunction

    task check_word(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report_mismatch("pending words", 0, 1);
        return;
      end
      want = pending.pop_front();
      if (got.m00 != want.m00) report_mismatch("m00", got.m00, want.m00);
      if (got.m01 != want.m01) report_mismatch("m01", got.m01, want.m01);
      if (got.m02 != want.m02) report_mismatch("m02", got.m02, want.m02);
      if (got.m10 != want.m10) report_mismatch("m10", got.m10, want.m10);
      if (got.m11 != want.m11) report_mismatch("m11", got.m11, want.m11);
      if (got.m12 != want.m12) report_mismatch("m12", got.m12, want.m12);
      if (got.m20 != want.m20) report_mismatch("m20", got.m20, want.m20);
      if (got.m21 != want.m21) report_mismatch("m21", got.m21, want.m21);
      if (got.m22 != want.m22) report_mismatch("m22", got.m22, want.m22);
      if (got.zero_axis != want.zero_axis)
        report_mismatch("zero_axis", got.zero_axis, want.zero_axis);
    endtask
  endclass

  matrix_scoreboard rot_board = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && start && !busy) rot_board.note_word(in_data);
    if (rst_n && out_strobe) begin
      if (out_data.zero_axis) zero_axis_seen++;
      rot_board.check_word(out_data);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // holds start until the word is taken, idling at random when allowed
  task automatic send_word(input in_word_t w, input bit may_idle);
    while (may_idle && $urandom_range(99) < 27) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(8)) - 4);
      3: return 16'h0;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    in_word_t w;
    logic [15:0] ex [6];
    ex = '{16'h8000, 16'h7FFF, 16'h0, 16'h1, 16'hFFFF, 16'h4000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // zero axis with various angles, then the extremes of each field
    w = '{16'sd0, 16'sd0, 16'sd0, 16'h0};      send_word(w, 0);
    w = '{16'sd0, 16'sd0, 16'sd0, 16'hFFFF};   send_word(w, 0);
    w = '{16'sd0, 16'sd0, 16'sd0, 16'h2000};   send_word(w, 0);
    for (int i = 0; i < 6; i++) begin
      w = '{ex[i], ex[(i + 1) % 6], ex[(i + 3) % 6], 16'(i * 16'h3000 + 16'h1FFF)};
      send_word(w, 0);
    end
    w = '{16'h8000, 16'h8000, 16'h8000, 16'h4000}; send_word(w, 0);
    w = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hC000}; send_word(w, 0);
    w = '{16'h0001, 16'h0000, 16'h0000, 16'h4000}; send_word(w, 0);
    w = '{16'h0000, 16'h0001, 16'h0000, 16'h8000}; send_word(w, 0);
    w = '{16'h0000, 16'h0000, 16'hFFFF, 16'hE000}; send_word(w, 0);
    w = '{16'h1234, 16'hEDCB, 16'h0F0F, 16'h2000}; send_word(w, 0);
    w = '{16'h0003, 16'h0004, 16'h0000, 16'hA000}; send_word(w, 0);
    for (int i = 0; i < 1750; i++) begin
      w.axis_x = rand_comp();
      w.axis_y = rand_comp();
      w.axis_z = rand_comp();
      w.angle = ($urandom_range(7) == 0) ? 16'($urandom_range(7) * 16'h2000) : 16'($urandom);
      // no idling through the middle stretch
      send_word(w, !(i > 600 && i < 900));
    end
    @(negedge clk);
    start <= 1'b0;
    while (rot_board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d words, %0d identity results for zero axes", words_sent, zero_axis_seen);
    $display("axis extremes, quadrant angles and random axis-angle pairs were checked");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
